/* hdl/slsd_pkg.sv */
// package for the seeded login stream decryptor
// item codes, register indexes, seed masks and the types shared by the modules
// no dependencies

package slsd_pkg;

    // field widths
    localparam int SEED_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int KEY_W    = 32;
    localparam int CFG_IDX_W = 1;

    // default header length in data bytes (legal range 61 to 255)
    localparam int HEADER_LENGTH_DEF = 62;

    // header positions that are checked
    localparam int HDR_POS_FIRST = 0;
    localparam int HDR_POS_MID   = 30;
    localparam int HDR_POS_LAST  = 60;

    localparam logic [BYTE_W-1:0] HDR_FIRST_VALUE = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_ZERO_VALUE  = 8'h00;

    // item kinds
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 1'b1;

    // seed masks
    localparam logic [15:0] MASK_LOW_HI  = 16'h1357;
    localparam logic [15:0] MASK_LOW_LO  = 16'haaaa;
    localparam logic [15:0] MASK_HIGH_LO = 16'h4321;
    localparam logic [15:0] MASK_HIGH_HI = 16'habcd;

    // work handed to the keystream unit for one item
    typedef struct packed {
        logic              load;
        logic              step;
        logic [SEED_W-1:0] seed;
        logic [BYTE_W-1:0] cipher_byte;
    } slsd_ctl_t;

    // result of one data item
    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              check_done;
        logic              check_ok;
    } slsd_res_t;

endpackage

/* hdl/seeded_login_stream_decrypt.sv */
// top level of the seeded login stream decryptor: input register, output register
// depends on slsd_pkg and slsd_keystream
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata = seed[31:0], cipher_byte[39:32]; tuser = kind
//  m_*       out  m_tvalid/m_tready  tdata = plain_byte; tlast = check_done; tuser = check_ok
//  cfg_*     in   cfg_we             cfg_index selects key_a (0) or key_b (1), cfg_data
//
// one item per cycle sustained while the output is not stalled; an accepted item
// is held in the input register, and its result then goes into the output register
// a seed item gives no result and is taken by the keystream unit like a data item
// reset clears the tables, keys, counter and both valid flags; the header flag sets
// when the output is stalled the input register holds one item, then s_tready drops

module seeded_login_stream_decrypt #(
    parameter int HEADER_LENGTH = slsd_pkg::HEADER_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // seed [31:0], cipher_byte [39:32]
    input  logic                           s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // plain_byte
    output logic                           m_tlast,   // check_done
    output logic                           m_tuser,   // check_ok
    input  logic                           cfg_we,
    input  logic [slsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slsd_pkg::KEY_W-1:0]     cfg_data
);
    import slsd_pkg::*;

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [SEED_W-1:0] in_seed_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    slsd_res_t         out_res_reg;

    logic              advance;
    slsd_ctl_t         ctl;
    slsd_res_t         res;

    // input register moves on when the output register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_seed_reg <= s_tdata[SEED_W-1:0];
            in_byte_reg <= s_tdata[SEED_W +: BYTE_W];
        end
    end

    always_comb
    begin
        ctl.load        = advance && (in_kind_reg == KIND_SEED);
        ctl.step        = advance && (in_kind_reg == KIND_DATA);
        ctl.seed        = in_seed_reg;
        ctl.cipher_byte = in_byte_reg;
    end

    slsd_keystream #(
        .HEADER_LENGTH(HEADER_LENGTH)
    ) u_keystream (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .res       (res)
    );

    always_comb
    begin
        if (ctl.step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.plain_byte;
    assign m_tlast  = out_res_reg.check_done;
    assign m_tuser  = out_res_reg.check_ok;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item not held in the input register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_tready) |-> (out_valid_reg && !m_tready))
        else $error("input stalled while the output side was free");

    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && !out_valid_reg) |=> !out_valid_reg)
        else $error("seed item produced a result");

endmodule

/* hdl/slsd_keystream.sv */
// keystream unit: key registers, the two shift tables, header counter and verdict
// depends on slsd_pkg

module slsd_keystream #(
    parameter int HEADER_LENGTH = slsd_pkg::HEADER_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slsd_pkg::KEY_W-1:0]     cfg_data,
    input  slsd_pkg::slsd_ctl_t            ctl,
    output slsd_pkg::slsd_res_t            res
);
    import slsd_pkg::*;

    localparam int CNT_W = $clog2(HEADER_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(HEADER_LENGTH);
    localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(HEADER_LENGTH - 1);
    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(HDR_POS_FIRST);
    localparam logic [CNT_W-1:0] CNT_MID   = CNT_W'(HDR_POS_MID);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(HDR_POS_LAST);

    logic [KEY_W-1:0]  key_a_reg, key_b_reg;
    logic [31:0]       table_low_reg, table_low_next;
    logic [31:0]       table_high_reg, table_high_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              good_reg, good_next;

    logic [31:0]       seed_inv;
    logic [31:0]       hi_half;
    logic              top_bit;
    logic [BYTE_W-1:0] plain;
    logic              in_header;
    logic              bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= '0;
            key_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_A: key_a_reg <= cfg_data;
                REG_KEY_B: key_b_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        seed_inv = ~ctl.seed;
        top_bit  = table_low_reg[0];
        // first of the two rotations of the high table
        hi_half  = {top_bit, table_high_reg[31:1]} ^ (key_a_reg - KEY_W'(1));
        plain    = ctl.cipher_byte ^ table_low_reg[BYTE_W-1:0];

        in_header = (cnt_reg < CNT_END);
        bad = ((cnt_reg == CNT_FIRST) && (plain != HDR_FIRST_VALUE))
            || (((cnt_reg == CNT_MID) || (cnt_reg == CNT_LAST)) && (plain != HDR_ZERO_VALUE));

        table_low_next  = table_low_reg;
        table_high_next = table_high_reg;
        cnt_next        = cnt_reg;
        good_next       = good_reg;

        if (ctl.load)
        begin
            table_low_next  = {seed_inv[15:0] ^ MASK_LOW_HI, ctl.seed[15:0] ^ MASK_LOW_LO};
            table_high_next = {seed_inv[31:16] ^ MASK_HIGH_HI, ctl.seed[31:16] ^ MASK_HIGH_LO};
            cnt_next        = '0;
            good_next       = 1'b1;
        end
        else if (ctl.step)
        begin
            table_high_next = {top_bit, hi_half[31:1]} ^ key_a_reg;
            table_low_next  = {table_high_reg[0], table_low_reg[31:1]} ^ key_b_reg;
            if (in_header)
            begin
                good_next = good_reg & ~bad;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
        end

        res.plain_byte = plain;
        res.check_done = in_header && (cnt_reg == CNT_FINAL);
        res.check_ok   = in_header && (cnt_reg == CNT_FINAL) && good_reg && !bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_low_reg  <= '0;
            table_high_reg <= '0;
            cnt_reg        <= '0;
            good_reg       <= 1'b1;
        end
        else
        begin
            table_low_reg  <= table_low_next;
            table_high_reg <= table_high_next;
            cnt_reg        <= cnt_next;
            good_reg       <= good_next;
        end
    end

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (cnt_reg == '0) && good_reg)
        else $error("seed load did not restart the header check");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("header counter ran past the header length");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.check_ok |-> res.check_done)
        else $error("verdict given outside the last header byte");

    a_good_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!good_reg && !ctl.load) |=> !good_reg)
        else $error("header failure cleared without a seed load");

endmodule

/* sim/seeded_login_stream_decrypt_tb.sv */
`timescale 1ns / 100ps
// testbench for seeded_login_stream_decrypt: streams seed and data items with random gaps
// and stalls, predicts every plain byte and header verdict and checks them in order
// depends on slsd_pkg and the block's rtl

module seeded_login_stream_decrypt_tb;

    import slsd_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  IDLE_PCT    = 13;
    localparam int  ITEM_TARGET = 600;
    localparam int  SETTLE_CYC  = 6;
    localparam int  RUN_LIMIT   = 2_000_000;

    // keystream state mirror; one copy checks results, another builds cipher bytes
    class login_decrypt_model;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [31:0]      tbl_lo;
        logic [31:0]      tbl_hi;
        int unsigned      count;
        bit               good;
        slsd_res_t        plain_q[$];
        int               errors;
        int               seeds;
        int               results;
        int               headers;
        int               headers_ok;

        function new();
            key_a      = '0;
            key_b      = '0;
            tbl_lo     = '0;
            tbl_hi     = '0;
            count      = 0;
            good       = 1'b1;
            errors     = 0;
            seeds      = 0;
            results    = 0;
            headers    = 0;
            headers_ok = 0;
        endfunction

        function void set_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
            if (idx == REG_KEY_A)
                key_a = val;
            else
                key_b = val;
        endfunction

        function logic [BYTE_W-1:0] key_byte();
            return tbl_lo[7:0];
        endfunction

        function int pending();
            return plain_q.size();
        endfunction

        // advances the state by one item, returns 1 when the item yields a result
        function bit decrypt_item(input logic kind, input logic [SEED_W-1:0] sd,
                                  input logic [BYTE_W-1:0] cb, output slsd_res_t res);
            logic [31:0] ns;
            logic [31:0] hi;
            logic [31:0] lo;
            logic        top;
            res = '0;
            if (kind == KIND_SEED)
            begin
                ns     = ~sd;
                tbl_lo = {ns[15:0] ^ MASK_LOW_HI, sd[15:0] ^ MASK_LOW_LO};
                tbl_hi = {ns[31:16] ^ MASK_HIGH_HI, sd[31:16] ^ MASK_HIGH_LO};
                count  = 0;
                good   = 1'b1;
                return 1'b0;
            end
            res.plain_byte = cb ^ tbl_lo[7:0];
            top = tbl_lo[0];
            hi  = {top, tbl_hi[31:1]} ^ (key_a - 32'd1);
            hi  = {top, hi[31:1]} ^ key_a;
            lo  = {tbl_hi[0], tbl_lo[31:1]} ^ key_b;
            tbl_lo = lo;
            tbl_hi = hi;
            // counter saturates at the header length
            if (count < HEADER_LENGTH_DEF)
            begin
                if (count == HDR_POS_FIRST && res.plain_byte != HDR_FIRST_VALUE)
                    good = 1'b0;
                if ((count == HDR_POS_MID || count == HDR_POS_LAST) &&
                    res.plain_byte != HDR_ZERO_VALUE)
                    good = 1'b0;
                if (count == HEADER_LENGTH_DEF - 1)
                begin
                    res.check_done = 1'b1;
                    res.check_ok   = good;
                end
                count++;
            end
            return 1'b1;
        endfunction

        function void note_item(input logic kind, input logic [SEED_W-1:0] sd,
                                input logic [BYTE_W-1:0] cb);
            slsd_res_t res;
            if (decrypt_item(kind, sd, cb, res))
                plain_q = {plain_q, res};
            else
                seeds++;
        endfunction

        function void check_result(input slsd_res_t got);
            slsd_res_t want;
            if (plain_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item outstanding, expected none, got %h",
                         $time, got);
                return;
            end
            want = plain_q.pop_front();
            results++;
            if (want.check_done)
            begin
                headers++;
                if (want.check_ok)
                    headers_ok++;
            end
            if (got.plain_byte != want.plain_byte)
            begin
                errors++;
                $display("%0t: plain_byte expected %02h got %02h",
                         $time, want.plain_byte, got.plain_byte);
            end
            if (got.check_done != want.check_done)
            begin
                errors++;
                $display("%0t: check_done expected %0b got %0b",
                         $time, want.check_done, got.check_done);
            end
            if (got.check_ok != want.check_ok)
            begin
                errors++;
                $display("%0t: check_ok expected %0b got %0b",
                         $time, want.check_ok, got.check_ok);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;

    login_decrypt_model sb  = new();
    login_decrypt_model enc = new();

    bit no_stall   = 1'b0;
    int items_sent = 0;

    seeded_login_stream_decrypt DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // sink with random back-pressure
    always @(posedge clk)
    begin
        m_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // note accepted items and check accepted results
    always @(posedge clk)
    begin
        slsd_res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[31:0], s_tdata[39:32]);
            if (m_tvalid && m_tready)
            begin
                got.plain_byte = m_tdata;
                got.check_done = m_tlast;
                got.check_ok   = m_tuser;
                sb.check_result(got);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [SEED_W-1:0] sd,
                             input logic [BYTE_W-1:0] cb);
        slsd_res_t unused;
        void'(enc.decrypt_item(kind, sd, cb, unused));
        while (!no_stall && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {cb, sd};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_seed(input logic [SEED_W-1:0] sd);
        send_item(KIND_SEED, sd, BYTE_W'($urandom_range(255)));
    endtask

    // encrypt the wanted plain byte with the keystream the block will use
    task automatic send_plain(input logic [BYTE_W-1:0] p);
        send_item(KIND_DATA, $urandom, p ^ enc.key_byte());
    endtask

    // wait until the block is idle before touching the keys
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_keys(input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_A;
        cfg_data  <= ka;
        @(posedge clk);
        sb.set_key(REG_KEY_A, ka);
        enc.set_key(REG_KEY_A, ka);
        cfg_index <= REG_KEY_B;
        cfg_data  <= kb;
        @(posedge clk);
        sb.set_key(REG_KEY_B, kb);
        enc.set_key(REG_KEY_B, kb);
        cfg_we <= 1'b0;
    endtask

    // a seed followed by len data bytes; a well-formed header unless broken
    task automatic run_stream(input int len, input bit broken);
        logic [BYTE_W-1:0] p;
        int                bad_pos;
        case ($urandom_range(7))
            0:       send_seed('0);
            1:       send_seed('1);
            default: send_seed($urandom);
        endcase
        bad_pos = broken ? $urandom_range(2) : -1;
        for (int i = 0; i < len; i++)
        begin
            p = BYTE_W'($urandom_range(255));
            if (i == HDR_POS_FIRST && bad_pos != 0)
                p = HDR_FIRST_VALUE;
            else if (i == HDR_POS_MID && bad_pos != 1)
                p = HDR_ZERO_VALUE;
            else if (i == HDR_POS_LAST && bad_pos != 2)
                p = HDR_ZERO_VALUE;
            else if (broken && (i == HDR_POS_FIRST || i == HDR_POS_MID || i == HDR_POS_LAST))
                p = p | 8'h01;
            send_plain(p);
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_SEED;
        cfg_we    = 1'b0;
        cfg_index = REG_KEY_A;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data before any seed runs on the zero tables
        send_item(KIND_DATA, 32'h0000_0000, 8'h00);
        send_item(KIND_DATA, 32'hffff_ffff, 8'hff);
        send_seed(32'h0000_0000);
        send_item(KIND_DATA, 32'hffff_ffff, 8'h00);
        send_item(KIND_DATA, 32'h0000_0000, 8'hff);
        settle();

        write_keys('1, '1);
        send_seed('1);
        send_plain(HDR_FIRST_VALUE);
        send_item(KIND_DATA, $urandom, 8'hff);
        send_item(KIND_DATA, $urandom, 8'h00);
        settle();

        // key change in the middle of a stream
        write_keys(32'h0000_0001, 32'h8000_0000);
        send_item(KIND_DATA, $urandom, 8'h5a);
        send_item(KIND_DATA, $urandom, 8'ha5);
        settle();

        write_keys('0, '0);
        send_seed($urandom);
        send_item(KIND_DATA, $urandom, BYTE_W'($urandom));
        send_item(KIND_SEED, $urandom, BYTE_W'($urandom));
        settle();

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(5))
                0:
                begin
                    ka = '0;
                    kb = '0;
                end
                1:
                begin
                    ka = '1;
                    kb = '1;
                end
                2:
                begin
                    ka = 32'h0000_0001;
                    kb = 32'h8000_0000;
                end
                default:
                begin
                    ka = $urandom;
                    kb = $urandom;
                end
            endcase
            write_keys(ka, kb);
            no_stall = (items_sent > 250 && items_sent < 400);
            // sometimes carry on with the old stream under the new keys
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 8)) send_plain(BYTE_W'($urandom_range(255)));
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: run_stream($urandom_range(62, 80), 1'b0);
                    4, 5:       run_stream($urandom_range(62, 70), 1'b1);
                    6, 7:       run_stream($urandom_range(0, 40), 1'b1);
                    default:
                        repeat ($urandom_range(2, 6))
                            send_item(logic'($urandom_range(1)), $urandom,
                                      BYTE_W'($urandom_range(255)));
                endcase
            end
            settle();
        end
        no_stall = 1'b0;
        settle();
        repeat (8) @(posedge clk);

        $display("covered %0d items: %0d seeds, %0d decrypted bytes, %0d headers checked",
                 items_sent, sb.seeds, sb.results, sb.headers);
        $display("%0d headers good, key pairs included all zeros and all ones", sb.headers_ok);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
